// ===== sv/pgvu_pkg.sv =====
package pgvu_pkg;

    // Field widths of the request, result and configuration channels.
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 31;
    localparam int WIDTH_W    = 5;
    localparam int SCALE_W    = 7;
    localparam int REF_W      = 32;
    localparam int COUNT_W    = 24;
    localparam int VALUE_W    = 48;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Bit accumulator: up to 31 held bits plus one new byte.
    localparam int ACC_W       = 39;
    localparam int HELD_W      = 6;
    localparam int MAX_RESULTS = 8;
    localparam int RES_CNT_W   = 4;

    localparam int QUEUE_DEPTH_DEF = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_WIDTH   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_EXP   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REF_WORD    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_COUNT = CFG_IDX_W'(3);

    // Configuration reset values.
    localparam logic [WIDTH_W-1:0] BIT_WIDTH_RST   = WIDTH_W'(8);
    localparam logic [COUNT_W-1:0] VALUE_COUNT_RST = COUNT_W'(1);

    // One extracted code on its way from the unpacker to the arithmetic.
    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              last;
    } t_code_entry;

    // Configuration seen by the unpacking front end.
    typedef struct packed {
        logic [WIDTH_W-1:0] bit_width;
        logic [COUNT_W-1:0] value_count;
    } t_front_cfg;

    // Configuration seen by the arithmetic back end.
    typedef struct packed {
        logic [SCALE_W-1:0] scale_exp;
        logic [REF_W-1:0]   ref_word;
    } t_back_cfg;

endpackage

// ===== sv/pgvu_if.sv =====
interface pgvu_in_if;
    logic                          valid;
    logic                          ready;
    logic [pgvu_pkg::BYTE_W-1:0]   data_byte;
    logic                          section_start;

    modport source (output valid, data_byte, section_start, input ready);
    modport sink   (input valid, data_byte, section_start, output ready);
endinterface

interface pgvu_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [pgvu_pkg::VALUE_W-1:0]  scaled_value;
    logic [pgvu_pkg::CODE_W-1:0]          raw_code;
    logic                                 saturated;
    logic                                 last_value;

    modport source (output valid, scaled_value, raw_code, saturated, last_value, input ready);
    modport sink   (input valid, scaled_value, raw_code, saturated, last_value, output ready);
endinterface

interface pgvu_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pgvu_pkg::CFG_IDX_W-1:0]    index;
    logic [pgvu_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/packed_grid_value_unpacker_top.sv =====
// Path: an accepted byte is held in the front-end accumulator; each code cut from it passes
// through the queue, stage 1 and stage 2 registers before it is presented at the output.
// Flow: a byte occupies the unpacker while it is loaded and its codes are extracted one at a
// time. The output side drains one value per cycle while o_out.ready is high; a short queue
// lets the two sides stall apart.
// Reset: synchronous, active low; clears the bit accumulator, counters and pipeline valids
// and returns the configuration registers to their reset values.
module packed_grid_value_unpacker_top #(
    parameter int QUEUE_DEPTH = pgvu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pgvu_in_if.sink     i_in,
    pgvu_cfg_if.sink    i_cfg,
    pgvu_out_if.source  o_out
);

    // Configuration registers. Writes must arrive only while the block is idle;
    // the block does not enforce this; the datapath reads them directly, with no shadow copy.
    logic [pgvu_pkg::WIDTH_W-1:0] r_bit_width;
    logic [pgvu_pkg::SCALE_W-1:0] r_scale_exp;
    logic [pgvu_pkg::REF_W-1:0]   r_ref_word;
    logic [pgvu_pkg::COUNT_W-1:0] r_value_count;

    pgvu_pkg::t_front_cfg  front_cfg;
    pgvu_pkg::t_back_cfg   back_cfg;

    // Code channel from the unpacker into the queue, and from the queue
    // into the arithmetic pipeline.
    logic                  push_valid, push_ready;
    pgvu_pkg::t_code_entry push_entry;
    logic                  pop_valid, pop_ready;
    pgvu_pkg::t_code_entry pop_entry;

    // The register port never stalls; an index beyond the list is dropped.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_width   <= pgvu_pkg::BIT_WIDTH_RST;
            r_scale_exp   <= '0;
            r_ref_word    <= '0;
            r_value_count <= pgvu_pkg::VALUE_COUNT_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pgvu_pkg::CFG_BIT_WIDTH: begin
                    r_bit_width <= i_cfg.data[pgvu_pkg::WIDTH_W-1:0];
                end
                pgvu_pkg::CFG_SCALE_EXP: begin
                    r_scale_exp <= i_cfg.data[pgvu_pkg::SCALE_W-1:0];
                end
                pgvu_pkg::CFG_REF_WORD: begin
                    r_ref_word <= i_cfg.data[pgvu_pkg::REF_W-1:0];
                end
                pgvu_pkg::CFG_VALUE_COUNT: begin
                    r_value_count <= i_cfg.data[pgvu_pkg::COUNT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign front_cfg.bit_width   = r_bit_width;
    assign front_cfg.value_count = r_value_count;
    assign back_cfg.scale_exp    = r_scale_exp;
    assign back_cfg.ref_word     = r_ref_word;

    // Front end: shifts each byte into the accumulator and cuts out one
    // code per cycle while the queue has room, tracking the section's value count and last flag.
    pgvu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (front_cfg),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .o_push_entry (push_entry),
        .i_push_ready (push_ready)
    );

    // Decoupling queue between extraction and arithmetic.
    pgvu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push_entry (push_entry),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_entry  (pop_entry),
        .i_pop_ready  (pop_ready)
    );

    // Back end: two stages. The first scales the reference and the code into
    // rounded Q16 magnitudes; the second adds, saturates and holds the result.
    pgvu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (back_cfg),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop_ready (pop_ready),
        .o_out       (o_out)
    );

endmodule

// ===== sv/pgvu_front.sv =====
module pgvu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pgvu_pkg::t_front_cfg  i_cfg,
    pgvu_in_if.sink               i_in,
    output logic                  o_push_valid,
    output pgvu_pkg::t_code_entry o_push_entry,
    input  logic                  i_push_ready
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state                              r_state, n_state;
    logic [pgvu_pkg::ACC_W-1:0]          r_acc, n_acc;
    logic [pgvu_pkg::HELD_W-1:0]         r_bits, n_bits;
    logic [pgvu_pkg::COUNT_W-1:0]        r_emitted, n_emitted;
    logic [pgvu_pkg::RES_CNT_W-1:0]      r_cnt, n_cnt;

    logic [pgvu_pkg::HELD_W-1:0]         width_eff;
    logic                                finished;
    logic                                extract;
    logic [pgvu_pkg::HELD_W-1:0]         shamt;
    logic [pgvu_pkg::ACC_W-1:0]          shifted;
    logic [pgvu_pkg::CODE_W-1:0]         code_mask;
    logic [pgvu_pkg::ACC_W-1:0]          fin_acc, base_acc;
    logic [pgvu_pkg::HELD_W-1:0]         fin_bits, base_bits;
    logic [pgvu_pkg::COUNT_W-1:0]        base_emitted;
    logic                                accept;

    always_comb begin
        // A width of zero behaves as a width of one.
        width_eff = (i_cfg.bit_width == '0) ? pgvu_pkg::HELD_W'(1)
                                            : pgvu_pkg::HELD_W'(i_cfg.bit_width);
        finished  = (r_emitted >= i_cfg.value_count);
        extract   = (r_state == ST_RUN) && (r_bits >= width_eff) && !finished &&
                    (r_cnt < pgvu_pkg::RES_CNT_W'(pgvu_pkg::MAX_RESULTS));
        shamt     = r_bits - width_eff;
        shifted   = r_acc >> shamt;
        code_mask = pgvu_pkg::CODE_W'((33'd1 << width_eff) - 33'd1);

        o_push_valid      = extract;
        o_push_entry.code = shifted[pgvu_pkg::CODE_W-1:0] & code_mask;
        o_push_entry.last = (({1'b0, r_emitted} + 25'd1) == {1'b0, i_cfg.value_count});

        // Wrap-up of the previous byte: a finished section drops its leftovers,
        // otherwise at most one code width of bits stays held.
        if (r_state == ST_IDLE) begin
            fin_acc  = r_acc;
            fin_bits = r_bits;
        end else if (finished) begin
            fin_acc  = '0;
            fin_bits = '0;
        end else begin
            fin_bits = (r_bits > pgvu_pkg::HELD_W'(pgvu_pkg::CODE_W))
                     ? pgvu_pkg::HELD_W'(pgvu_pkg::CODE_W) : r_bits;
            fin_acc  = r_acc & pgvu_pkg::ACC_W'((40'd1 << fin_bits) - 40'd1);
        end

        // The next byte is taken as soon as no more codes are due.
        i_in.ready = !extract;
        accept     = i_in.valid && !extract;

        if (i_in.section_start) begin
            base_acc     = '0;
            base_bits    = '0;
            base_emitted = '0;
        end else begin
            base_acc     = fin_acc;
            base_bits    = fin_bits;
            base_emitted = r_emitted;
        end

        n_state   = r_state;
        n_acc     = r_acc;
        n_bits    = r_bits;
        n_emitted = r_emitted;
        n_cnt     = r_cnt;

        if (accept) begin
            n_acc     = base_acc;
            n_bits    = base_bits;
            n_emitted = base_emitted;
            n_cnt     = '0;
            if (base_emitted >= i_cfg.value_count) begin
                n_state = ST_IDLE;
            end else begin
                n_state = ST_RUN;
                n_acc   = {base_acc[pgvu_pkg::ACC_W-pgvu_pkg::BYTE_W-1:0], i_in.data_byte};
                n_bits  = base_bits + pgvu_pkg::HELD_W'(pgvu_pkg::BYTE_W);
            end
        end else if (extract) begin
            if (i_push_ready) begin
                n_bits    = r_bits - width_eff;
                n_emitted = r_emitted + pgvu_pkg::COUNT_W'(1);
                n_cnt     = r_cnt + pgvu_pkg::RES_CNT_W'(1);
            end
        end else if (r_state == ST_RUN) begin
            n_state = ST_IDLE;
            n_acc   = fin_acc;
            n_bits  = fin_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_acc     <= '0;
            r_bits    <= '0;
            r_emitted <= '0;
            r_cnt     <= '0;
        end else begin
            r_state   <= n_state;
            r_acc     <= n_acc;
            r_bits    <= n_bits;
            r_emitted <= n_emitted;
            r_cnt     <= n_cnt;
        end
    end

    // No byte yields more than the per-byte result limit.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= pgvu_pkg::RES_CNT_W'(pgvu_pkg::MAX_RESULTS))
        else $error("front: result count per byte exceeded");

    // Between bytes the accumulator never holds more than one code width.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_bits <= pgvu_pkg::HELD_W'(pgvu_pkg::CODE_W)))
        else $error("front: too many bits held while idle");

endmodule

// ===== sv/pgvu_queue.sv =====
module pgvu_queue #(
    parameter int DEPTH = pgvu_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push_valid,
    input  pgvu_pkg::t_code_entry i_push_entry,
    output logic                  o_push_ready,
    output logic                  o_pop_valid,
    output pgvu_pkg::t_code_entry o_pop_entry,
    input  logic                  i_pop_ready
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pgvu_pkg::t_code_entry r_mem [DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic                  push, pop;

    always_comb begin
        o_push_ready = (r_count < CNT_W'(DEPTH));
        o_pop_valid  = (r_count != '0);
        o_pop_entry  = r_mem[r_rd_ptr];
        push         = i_push_valid && o_push_ready;
        pop          = o_pop_valid && i_pop_ready;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue: occupancy above depth");

    // Occupancy moves by at most one entry per cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> ((r_count == $past(r_count)) ||
                  (r_count == $past(r_count) + CNT_W'(1)) ||
                  (r_count == $past(r_count) - CNT_W'(1))))
        else $error("queue: occupancy jumped");

endmodule

// ===== sv/pgvu_back.sv =====
module pgvu_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pgvu_pkg::t_back_cfg   i_cfg,
    input  logic                  i_pop_valid,
    input  pgvu_pkg::t_code_entry i_pop_entry,
    output logic                  o_pop_ready,
    pgvu_out_if.source            o_out
);

    localparam int MAG_W   = 62;
    localparam int SH_W    = 10;
    localparam int WIDE_W  = MAG_W + 32;
    localparam int SUM_W   = 64;
    localparam int FRAC_W  = 24;
    localparam int EXP_W   = 7;
    localparam int RND_MAX = 40;

    localparam logic signed [SH_W-1:0]  REF_SH_BIAS = SH_W'(264);
    localparam logic signed [SH_W-1:0]  CODE_SH_OFS = SH_W'(16);
    localparam logic signed [SUM_W-1:0] OUT_MAX     = 64'sd140737488355327;
    localparam logic signed [SUM_W-1:0] OUT_MIN     = -64'sd140737488355328;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             clip;
    } t_mag;

    // round(m * 2^sh), ties away from zero, magnitude clipped to 2^62 - 1.
    function automatic t_mag scale_mag(input logic [31:0] m,
                                       input logic signed [SH_W-1:0] sh);
        t_mag              res;
        logic [WIDE_W-1:0] prod;
        logic [SH_W-1:0]   n;
        logic [5:0]        n1;
        logic [31:0]       q;
        logic [32:0]       qr;
        res  = '0;
        prod = '0;
        n    = '0;
        n1   = '0;
        q    = '0;
        qr   = '0;
        if (m == '0) begin
            res = '0;
        end else if (!sh[SH_W-1]) begin
            if (sh >= SH_W'(MAG_W)) begin
                res.mag  = '1;
                res.clip = 1'b1;
            end else begin
                prod = WIDE_W'(m) << sh[5:0];
                if (|prod[WIDE_W-1:MAG_W]) begin
                    res.mag  = '1;
                    res.clip = 1'b1;
                end else begin
                    res.mag = prod[MAG_W-1:0];
                end
            end
        end else begin
            n = SH_W'(-sh);
            if (n < SH_W'(RND_MAX)) begin
                n1      = n1 + 6'(n - SH_W'(1));
                q       = m >> n1;
                qr      = {1'b0, q} + 33'd1;
                res.mag = MAG_W'(qr[32:1]);
            end
        end
        return res;
    endfunction

    logic                             r_s1_valid;
    logic [MAG_W-1:0]                 r_s1_ref_mag, r_s1_code_mag;
    logic                             r_s1_clip, r_s1_neg;
    pgvu_pkg::t_code_entry            r_s1_entry;

    logic                             r_s2_valid;
    logic signed [pgvu_pkg::VALUE_W-1:0] r_s2_value;
    logic                             r_s2_sat;
    pgvu_pkg::t_code_entry            r_s2_entry;

    logic                             adv1, adv2;
    logic [EXP_W-1:0]                 ref_exp;
    logic signed [SH_W-1:0]           ref_sh, code_sh;
    t_mag                             ref_res, code_res;
    logic signed [SUM_W-1:0]          ref_signed, sum;
    logic signed [pgvu_pkg::VALUE_W-1:0] value;
    logic                             sum_clip;

    always_comb begin
        adv2        = !r_s2_valid || o_out.ready;
        adv1        = !r_s1_valid || adv2;
        o_pop_ready = adv1;

        // Stage 1: reference term f * 2^(4e-264) and code term x * 2^(s+16).
        ref_exp  = i_cfg.ref_word[pgvu_pkg::REF_W-2 -: EXP_W];
        ref_sh   = $signed({1'b0, ref_exp, 2'b00}) - REF_SH_BIAS;
        code_sh  = $signed({{(SH_W-pgvu_pkg::SCALE_W){i_cfg.scale_exp[pgvu_pkg::SCALE_W-1]}},
                            i_cfg.scale_exp}) + CODE_SH_OFS;
        ref_res  = scale_mag({8'b0, i_cfg.ref_word[FRAC_W-1:0]}, ref_sh);
        code_res = scale_mag({1'b0, i_pop_entry.code}, code_sh);

        // Stage 2: signed sum, clipped to the 48-bit result range.
        ref_signed = r_s1_neg ? -$signed({2'b00, r_s1_ref_mag})
                              :  $signed({2'b00, r_s1_ref_mag});
        sum        = ref_signed + $signed({2'b00, r_s1_code_mag});
        sum_clip   = 1'b0;
        value      = sum[pgvu_pkg::VALUE_W-1:0];
        if (sum > OUT_MAX) begin
            value    = OUT_MAX[pgvu_pkg::VALUE_W-1:0];
            sum_clip = 1'b1;
        end else if (sum < OUT_MIN) begin
            value    = OUT_MIN[pgvu_pkg::VALUE_W-1:0];
            sum_clip = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (adv1) begin
                r_s1_valid <= i_pop_valid;
            end
            if (adv2) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_s1_ref_mag  <= ref_res.mag;
            r_s1_code_mag <= code_res.mag;
            r_s1_clip     <= ref_res.clip || code_res.clip;
            r_s1_neg      <= i_cfg.ref_word[pgvu_pkg::REF_W-1];
            r_s1_entry    <= i_pop_entry;
        end
        if (adv2) begin
            r_s2_value <= value;
            r_s2_sat   <= r_s1_clip || sum_clip;
            r_s2_entry <= r_s1_entry;
        end
    end

    assign o_out.valid        = r_s2_valid;
    assign o_out.scaled_value = r_s2_value;
    assign o_out.raw_code     = r_s2_entry.code;
    assign o_out.saturated    = r_s2_sat;
    assign o_out.last_value   = r_s2_entry.last;

endmodule
